/* rtl/core/ifr_pkg.sv */
package ifr_pkg;

   localparam int FRAC_BITS  = 4;
   localparam int INT_BITS   = 16;
   localparam int IN_W       = INT_BITS + FRAC_BITS;
   localparam int POS_IN_W   = IN_W + 1;
   localparam int OUT_W      = IN_W + 4;
   localparam int POS_OUT_W  = OUT_W + 1;
   localparam int PROD_W     = 2 * IN_W;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = PROD_W / DIV_BITS;
   localparam int DIFF_W     = PROD_W + 2;
   localparam int POS_W      = DIFF_W + 1;
   localparam int LATENCY    = DIV_STAGES + 4;

   localparam logic [2:0] MODE_COVER   = 3'd0;
   localparam logic [2:0] MODE_CONTAIN = 3'd1;
   localparam logic [2:0] MODE_CENTER  = 3'd2;
   localparam logic [2:0] MODE_REPEAT  = 3'd3;
   localparam logic [2:0] MODE_STRETCH = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_MODE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_TGT = 2'd0,
      KIND_NAT = 2'd1,
      KIND_WQ  = 2'd2,
      KIND_HQ  = 2'd3
   } fit_kind_type;

   typedef struct packed {
      logic signed [POS_IN_W-1:0] tx;
      logic signed [POS_IN_W-1:0] ty;
      logic [IN_W-1:0]            sw;
      logic [IN_W-1:0]            sh;
      logic [IN_W-1:0]            tw;
      logic [IN_W-1:0]            th;
      fit_kind_type               kind;
      logic                       cx;
      logic                       cy;
      logic [1:0]                 status;
   } item_type;

   typedef struct packed {
      logic [IN_W-1:0]     rem;
      logic [DIV_BITS-1:0] q;
   } div_step_type;

   function automatic div_step_type div_step(input logic [IN_W-1:0] rem,
                                             input logic [DIV_BITS-1:0] bits,
                                             input logic [IN_W-1:0] den);
      logic [IN_W:0]       t;
      logic [IN_W-1:0]     r;
      logic [DIV_BITS-1:0] qv;
      div_step_type        res;
      r  = rem;
      qv = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, den}) begin
            t     = t - {1'b0, den};
            qv[i] = 1'b1;
         end
         r = t[IN_W-1:0];
      end
      res.rem = r;
      res.q   = qv;
      return res;
   endfunction

endpackage

/* rtl/core/image_fit_rect_compute.sv */
// Image fit rectangle: one request may be started every cycle and busy stays low; each
// result is taken LATENCY = DIV_STAGES + 4 clock edges (24 at Q16.4) after the edge that
// took its request, is on the ports for one cycle with rsp_valid, and must be taken then.
// The latency is set by the pipelined restoring divider, which resolves two quotient bits
// per stage over the 40-bit product, plus the product, decode, centering and output stages.
module image_fit_rect_compute
   import ifr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [IN_W-1:0]             req_src_width,
   input  logic [IN_W-1:0]             req_src_height,
   input  logic signed [POS_IN_W-1:0]  req_target_x,
   input  logic signed [POS_IN_W-1:0]  req_target_y,
   input  logic [IN_W-1:0]             req_target_width,
   input  logic [IN_W-1:0]             req_target_height,
   input  logic [2:0]                  req_resize_mode,
   output logic                        rsp_valid,
   output logic signed [POS_OUT_W-1:0] rsp_out_x,
   output logic signed [POS_OUT_W-1:0] rsp_out_y,
   output logic [OUT_W-1:0]            rsp_out_width,
   output logic [OUT_W-1:0]            rsp_out_height,
   output logic [1:0]                  rsp_status
);

   logic                       a_valid_ff;
   logic [PROD_W-1:0]          a_p1_ff, a_p2_ff;
   logic [IN_W-1:0]            a_sw_ff, a_sh_ff, a_tw_ff, a_th_ff;
   logic signed [POS_IN_W-1:0] a_tx_ff, a_ty_ff;
   logic [2:0]                 a_mode_ff;

   logic                       d_valid_ff [0:DIV_STAGES];
   item_type                   d_item_ff  [0:DIV_STAGES];
   logic [IN_W-1:0]            d_rem_ff   [0:DIV_STAGES];
   logic [IN_W-1:0]            d_den_ff   [0:DIV_STAGES];
   logic [PROD_W-1:0]          d_num_ff   [0:DIV_STAGES];
   logic [PROD_W-1:0]          d_q_ff     [0:DIV_STAGES];

   item_type                   b_item_in;
   logic [IN_W-1:0]            b_den_in;
   logic [PROD_W-1:0]          b_num_in;
   logic                       taller, zero;

   logic                       f_valid_ff;
   logic signed [POS_W-1:0]    f_x_ff, f_y_ff;
   logic [PROD_W-1:0]          f_w_ff, f_h_ff;
   logic [1:0]                 f_status_ff;

   logic signed [POS_W-1:0]    f_x_in, f_y_in;
   logic [PROD_W-1:0]          f_w_in, f_h_in;
   logic signed [DIFF_W-1:0]   dx, dy;

   logic signed [POS_OUT_W-1:0] x_in, y_in;
   logic [OUT_W-1:0]            w_in, h_in;

   localparam logic signed [POS_W-1:0] POS_MAX = POS_W'((64'sd1 <<< OUT_W) - 1);
   localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(64'sd1 <<< OUT_W);
   localparam logic [PROD_W-1:0]       LEN_MAX = PROD_W'((64'd1 << OUT_W) - 1);

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_p1_ff   <= PROD_W'(req_target_width) * PROD_W'(req_src_height);
      a_p2_ff   <= PROD_W'(req_src_width) * PROD_W'(req_target_height);
      a_sw_ff   <= req_src_width;
      a_sh_ff   <= req_src_height;
      a_tw_ff   <= req_target_width;
      a_th_ff   <= req_target_height;
      a_tx_ff   <= req_target_x;
      a_ty_ff   <= req_target_y;
      a_mode_ff <= req_resize_mode;
   end

   always_comb begin
      zero   = (a_sw_ff == '0) || (a_sh_ff == '0) || (a_tw_ff == '0) || (a_th_ff == '0);
      taller = a_p1_ff <= a_p2_ff;
      b_item_in.tx     = a_tx_ff;
      b_item_in.ty     = a_ty_ff;
      b_item_in.sw     = a_sw_ff;
      b_item_in.sh     = a_sh_ff;
      b_item_in.tw     = a_tw_ff;
      b_item_in.th     = a_th_ff;
      b_item_in.kind   = KIND_TGT;
      b_item_in.cx     = 1'b0;
      b_item_in.cy     = 1'b0;
      b_item_in.status = STATUS_OK;
      if (zero) begin
         b_item_in.status = STATUS_ZERO;
      end else begin
         case (a_mode_ff)
            MODE_COVER: begin
               b_item_in.kind = taller ? KIND_WQ : KIND_HQ;
               b_item_in.cx   = taller;
               b_item_in.cy   = !taller;
            end
            MODE_CONTAIN: begin
               b_item_in.kind = taller ? KIND_HQ : KIND_WQ;
               b_item_in.cx   = 1'b1;
               b_item_in.cy   = 1'b1;
            end
            MODE_CENTER: begin
               if (a_sw_ff > a_tw_ff) b_item_in.kind = KIND_WQ;
               else if (a_sh_ff > a_th_ff) b_item_in.kind = KIND_HQ;
               else b_item_in.kind = KIND_NAT;
               b_item_in.cx = 1'b1;
               b_item_in.cy = 1'b1;
            end
            MODE_REPEAT: begin
               if (a_sw_ff <= a_tw_ff && a_sh_ff <= a_th_ff) b_item_in.kind = KIND_NAT;
               else b_item_in.kind = taller ? KIND_HQ : KIND_WQ;
            end
            MODE_STRETCH: begin
               b_item_in.kind = KIND_TGT;
            end
            default: begin
               b_item_in.status = STATUS_MODE;
            end
         endcase
      end
      if (b_item_in.kind == KIND_WQ) begin
         b_num_in = a_p2_ff;
         b_den_in = a_sh_ff;
      end else begin
         b_num_in = a_p1_ff;
         b_den_in = a_sw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else begin
         d_valid_ff[0] <= a_valid_ff;
      end
      d_item_ff[0] <= b_item_in;
      d_rem_ff[0]  <= '0;
      d_den_ff[0]  <= b_den_in;
      d_num_ff[0]  <= b_num_in;
      d_q_ff[0]    <= '0;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      div_step_type step;
      assign step = div_step(d_rem_ff[s], d_num_ff[s][PROD_W-1 -: DIV_BITS], d_den_ff[s]);
      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[s+1] <= 1'b0;
         end else begin
            d_valid_ff[s+1] <= d_valid_ff[s];
         end
         d_item_ff[s+1] <= d_item_ff[s];
         d_rem_ff[s+1]  <= step.rem;
         d_den_ff[s+1]  <= d_den_ff[s];
         d_num_ff[s+1]  <= d_num_ff[s] << DIV_BITS;
         d_q_ff[s+1]    <= {d_q_ff[s][PROD_W-DIV_BITS-1:0], step.q};
      end
   end

   always_comb begin
      case (d_item_ff[DIV_STAGES].kind)
         KIND_WQ: begin
            f_w_in = d_q_ff[DIV_STAGES];
            f_h_in = PROD_W'(d_item_ff[DIV_STAGES].th);
         end
         KIND_HQ: begin
            f_w_in = PROD_W'(d_item_ff[DIV_STAGES].tw);
            f_h_in = d_q_ff[DIV_STAGES];
         end
         KIND_NAT: begin
            f_w_in = PROD_W'(d_item_ff[DIV_STAGES].sw);
            f_h_in = PROD_W'(d_item_ff[DIV_STAGES].sh);
         end
         default: begin
            f_w_in = PROD_W'(d_item_ff[DIV_STAGES].tw);
            f_h_in = PROD_W'(d_item_ff[DIV_STAGES].th);
         end
      endcase
      dx = $signed(DIFF_W'(d_item_ff[DIV_STAGES].tw)) - $signed({2'b00, f_w_in});
      dy = $signed(DIFF_W'(d_item_ff[DIV_STAGES].th)) - $signed({2'b00, f_h_in});
      f_x_in = POS_W'(d_item_ff[DIV_STAGES].tx);
      f_y_in = POS_W'(d_item_ff[DIV_STAGES].ty);
      if (d_item_ff[DIV_STAGES].cx) f_x_in = f_x_in + POS_W'(dx >>> 1);
      if (d_item_ff[DIV_STAGES].cy) f_y_in = f_y_in + POS_W'(dy >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= d_valid_ff[DIV_STAGES];
      end
      f_x_ff      <= f_x_in;
      f_y_ff      <= f_y_in;
      f_w_ff      <= f_w_in;
      f_h_ff      <= f_h_in;
      f_status_ff <= d_item_ff[DIV_STAGES].status;
   end

   always_comb begin
      if (f_x_ff > POS_MAX) x_in = POS_MAX[POS_OUT_W-1:0];
      else if (f_x_ff < POS_MIN) x_in = POS_MIN[POS_OUT_W-1:0];
      else x_in = f_x_ff[POS_OUT_W-1:0];
      if (f_y_ff > POS_MAX) y_in = POS_MAX[POS_OUT_W-1:0];
      else if (f_y_ff < POS_MIN) y_in = POS_MIN[POS_OUT_W-1:0];
      else y_in = f_y_ff[POS_OUT_W-1:0];
      w_in = (f_w_ff > LEN_MAX) ? LEN_MAX[OUT_W-1:0] : f_w_ff[OUT_W-1:0];
      h_in = (f_h_ff > LEN_MAX) ? LEN_MAX[OUT_W-1:0] : f_h_ff[OUT_W-1:0];
   end

   logic                        rsp_valid_ff;
   logic signed [POS_OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [OUT_W-1:0]            rsp_w_ff, rsp_h_ff;
   logic [1:0]                  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid_ff;
      end
      rsp_x_ff      <= x_in;
      rsp_y_ff      <= y_in;
      rsp_w_ff      <= w_in;
      rsp_h_ff      <= h_in;
      rsp_status_ff <= f_status_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_width  = rsp_w_ff;
   assign rsp_out_height = rsp_h_ff;
   assign rsp_status     = rsp_status_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not produce a response at fixed latency");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_ZERO ||
                     rsp_status == STATUS_MODE))
      else $error("invalid status code");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

endmodule

/* tb/sv/image_fit_rect_compute_tb.sv */
module image_fit_rect_compute_tb;
   import ifr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [POS_OUT_W-1:0] x;
      logic signed [POS_OUT_W-1:0] y;
      logic [OUT_W-1:0]            w;
      logic [OUT_W-1:0]            h;
      logic [1:0]                  status;
   } rect_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [IN_W-1:0]             req_src_width = '0;
   logic [IN_W-1:0]             req_src_height = '0;
   logic signed [POS_IN_W-1:0]  req_target_x = '0;
   logic signed [POS_IN_W-1:0]  req_target_y = '0;
   logic [IN_W-1:0]             req_target_width = '0;
   logic [IN_W-1:0]             req_target_height = '0;
   logic [2:0]                  req_resize_mode = '0;
   logic                        rsp_valid;
   logic signed [POS_OUT_W-1:0] rsp_out_x;
   logic signed [POS_OUT_W-1:0] rsp_out_y;
   logic [OUT_W-1:0]            rsp_out_width;
   logic [OUT_W-1:0]            rsp_out_height;
   logic [1:0]                  rsp_status;

   rect_type expected_rects[$];
   int       error_count = 0;
   int       request_count = 0;
   int       rect_count = 0;
   int       idle_cycles = 0;
   int       gap_pct = 0;
   bit       timed_out = 0;

   image_fit_rect_compute uut (.*);

   always #1 clock = ~clock;

   function automatic longint scaled_side(longint a, longint num, longint den);
      longint q;
      q = (a * num) / den;
      return (q > (64'sd1 << 48)) ? (64'sd1 << 48) : q;
   endfunction

   function automatic longint centered(longint pos, longint tside, longint side);
      return pos + ((tside - side) >>> 1);
   endfunction

   function automatic rect_type fit_rect(longint sw, longint sh, longint tx, longint ty,
                                         longint tw, longint th, logic [2:0] mode);
      longint   x, y, w, h, umax;
      bit       taller;
      rect_type r;
      x = tx; y = ty; w = tw; h = th;
      umax = (64'sd1 << OUT_W) - 1;
      r.status = STATUS_OK;
      if (sw == 0 || sh == 0 || tw == 0 || th == 0) begin
         r.status = STATUS_ZERO;
      end else begin
         taller = (tw * sh) <= (sw * th);
         case (mode)
            MODE_COVER: begin
               if (taller) begin
                  w = scaled_side(th, sw, sh);
                  x = centered(tx, tw, w);
               end else begin
                  h = scaled_side(tw, sh, sw);
                  y = centered(ty, th, h);
               end
            end
            MODE_CONTAIN, MODE_REPEAT: begin
               if (mode == MODE_REPEAT && sw <= tw && sh <= th) begin
                  w = sw;
                  h = sh;
               end else begin
                  if (taller) h = scaled_side(tw, sh, sw);
                  else w = scaled_side(th, sw, sh);
                  if (mode == MODE_CONTAIN) begin
                     x = centered(tx, tw, w);
                     y = centered(ty, th, h);
                  end
               end
            end
            MODE_CENTER: begin
               w = sw;
               h = sh;
               if (sh > th) begin
                  w = tw;
                  h = scaled_side(tw, sh, sw);
               end
               if (sw > tw) begin
                  h = th;
                  w = scaled_side(th, sw, sh);
               end
               x = centered(tx, tw, w);
               y = centered(ty, th, h);
            end
            MODE_STRETCH: ;
            default: r.status = STATUS_MODE;
         endcase
      end
      if (x > umax) x = umax;
      if (x < -umax - 1) x = -umax - 1;
      if (y > umax) y = umax;
      if (y < -umax - 1) y = -umax - 1;
      r.x = x[POS_OUT_W-1:0];
      r.y = y[POS_OUT_W-1:0];
      r.w = (w > umax) ? umax[OUT_W-1:0] : w[OUT_W-1:0];
      r.h = (h > umax) ? umax[OUT_W-1:0] : h[OUT_W-1:0];
      return r;
   endfunction

   task automatic send_request(logic [IN_W-1:0] sw, logic [IN_W-1:0] sh,
                               logic signed [POS_IN_W-1:0] tx,
                               logic signed [POS_IN_W-1:0] ty,
                               logic [IN_W-1:0] tw, logic [IN_W-1:0] th,
                               logic [2:0] mode);
      while ($urandom_range(99, 0) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_src_width     <= sw;
      req_src_height    <= sh;
      req_target_x      <= tx;
      req_target_y      <= ty;
      req_target_width  <= tw;
      req_target_height <= th;
      req_resize_mode   <= mode;
      do @(posedge clock); while (busy);
      expected_rects.push_back(fit_rect(sw, sh, tx, ty, tw, th, mode));
      request_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rects.size() != 0) @(negedge clock);
   endtask

   function automatic logic [IN_W-1:0] rand_side();
      case ($urandom_range(3, 0))
         0: return IN_W'($urandom_range(40, 1));
         1: return IN_W'($urandom_range(16000, 1));
         2: return IN_W'($urandom);
         default: return {$urandom_range(1, 0) ? 4'hf : 4'h0, 16'($urandom)};
      endcase
   endfunction

   task automatic test_directed();
      logic [IN_W-1:0] mx;
      mx = '1;
      for (int m = 0; m < 8; m++) begin
         send_request(20'd160, 20'd90, -21'sd5, 21'sd7, 20'd320, 20'd320, 3'(m));
         send_request(mx, 20'd1, 21'sh0FFFFF, 21'sh100000, 20'd1, mx, 3'(m));
      end
      send_request(20'd0, 20'd5, 21'sd0, 21'sd0, 20'd5, 20'd5, MODE_COVER);
      send_request(20'd5, 20'd0, 21'sd3, 21'sd3, 20'd5, 20'd5, MODE_CONTAIN);
      send_request(20'd5, 20'd5, 21'sd3, 21'sd3, 20'd0, 20'd5, MODE_CENTER);
      send_request(20'd5, 20'd5, 21'sd3, 21'sd3, 20'd5, 20'd0, 3'd7);
      send_request(mx, mx, 21'sh100000, 21'sh100000, mx, mx, MODE_REPEAT);
      send_request(20'd3, mx, 21'sh0FFFFF, 21'sh0FFFFF, mx, 20'd1, MODE_CENTER);
      send_request(20'd7, 20'd3, 21'sd0, 21'sd0, 20'd2, 20'd2, MODE_CENTER);
      send_request(mx, 20'd1, 21'sh100000, 21'sh100000, 20'd1, mx, MODE_CONTAIN);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [IN_W-1:0] sw, sh, tw, th;
      for (int i = 0; i < count; i++) begin
         sw = rand_side();
         sh = rand_side();
         tw = rand_side();
         th = rand_side();
         if ($urandom_range(19, 0) == 0) sw = '0;
         if ($urandom_range(19, 0) == 0) th = '0;
         send_request(sw, sh, POS_IN_W'($urandom), POS_IN_W'($urandom), tw, th,
                      ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5))
                                                   : 3'($urandom_range(4, 0)));
         if (i == count / 2) wait_drained();
      end
   endtask

   always @(posedge clock) begin
      rect_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            rect_count++;
            if (expected_rects.size() == 0) begin
               $display("%0t: unexpected result x=%0d", $time, rsp_out_x);
               error_count++;
            end else begin
               e = expected_rects.pop_front();
               if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_width !== e.w ||
                   rsp_out_height !== e.h || rsp_status !== e.status) begin
                  $display("%0t: expected x=%0d y=%0d w=%0d h=%0d st=%0d", $time,
                           e.x, e.y, e.w, e.h, e.status);
                  $display("%0t: actual   x=%0d y=%0d w=%0d h=%0d st=%0d", $time,
                           rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height,
                           rsp_status);
                  error_count++;
               end
            end
         end
         if (idle_cycles > WATCHDOG_LIMIT) timed_out = 1;
      end
   end

   initial begin
      wait (timed_out);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      gap_pct = 7;
      test_random(370);
      gap_pct = 66;
      test_random(350);
      gap_pct = 0;
      test_random(370);
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      $display("Covered %0d requests and %0d rectangles over all fit modes,", request_count,
               rect_count);
      $display("zero sizes, reserved modes, saturation and sender gaps.");
      if (error_count == 0 && expected_rects.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
